### rtl/r2p_pkg.sv
// shared types, constants and the arctangent table for the rectangular-to-polar core
package r2p_pkg;

    // default configuration
    localparam int COORD_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    // x and y enter the rotations scaled so that full scale, 2^(COORD_WIDTH-1), sits at 2^59
    localparam int XY_SCALE_EXP = 60;
    // rotation datapath width: |vector| * cordic gain stays below 2^61
    localparam int XY_W         = 63;

    // angle accumulator: degrees, 20 fraction bits, |z| < 2^28
    localparam int ANG_FRAC     = 20;
    localparam int ANG_W        = 30;
    localparam int OUT_FRAC     = 7;
    localparam int ANG_DROP     = ANG_FRAC - OUT_FRAC;
    localparam int OUT_W        = 16;

    localparam logic signed [ANG_W-1:0] DEG90    = ANG_W'(90 * (2 ** ANG_FRAC));
    localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(2 ** (ANG_DROP - 1));
    localparam logic signed [OUT_W-1:0] DEG180_OUT = OUT_W'(180 * (2 ** OUT_FRAC));

    // input word
    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
    } in_word_t;

    // result word
    typedef struct packed {
        logic        [15:0] magnitude;
        logic signed [15:0] angle_deg;
    } out_word_t;

    // rotation state carried down the pipeline
    typedef struct packed {
        logic signed [XY_W-1:0]  cx;
        logic signed [XY_W-1:0]  cy;
        logic signed [ANG_W-1:0] z;
        logic                    on_axis;  // y was zero
        logic                    neg_x;    // x was negative
    } cordic_t;

    // atan(2^-k) in degrees, 20 fraction bits, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] k);
        logic signed [ANG_W-1:0] v;
        unique case (k)
            5'd0:    v = ANG_W'(47185920);
            5'd1:    v = ANG_W'(27855475);
            5'd2:    v = ANG_W'(14718068);
            5'd3:    v = ANG_W'(7471121);
            5'd4:    v = ANG_W'(3750058);
            5'd5:    v = ANG_W'(1876857);
            5'd6:    v = ANG_W'(938658);
            5'd7:    v = ANG_W'(469357);
            5'd8:    v = ANG_W'(234682);
            5'd9:    v = ANG_W'(117342);
            5'd10:   v = ANG_W'(58671);
            5'd11:   v = ANG_W'(29335);
            5'd12:   v = ANG_W'(14668);
            5'd13:   v = ANG_W'(7334);
            5'd14:   v = ANG_W'(3667);
            5'd15:   v = ANG_W'(1833);
            5'd16:   v = ANG_W'(917);
            5'd17:   v = ANG_W'(458);
            5'd18:   v = ANG_W'(229);
            5'd19:   v = ANG_W'(115);
            5'd20:   v = ANG_W'(57);
            5'd21:   v = ANG_W'(29);
            5'd22:   v = ANG_W'(14);
            5'd23:   v = ANG_W'(7);
            5'd24:   v = ANG_W'(4);
            5'd25:   v = ANG_W'(2);
            5'd26:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/r2p_step.sv
// one pipeline stage: cordic micro-rotation and/or one bit of the square root
module r2p_step
    import r2p_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int STEP         = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       valid_in,
    input  cordic_t                    cor_in,
    input  logic [2*COORD_WIDTH-1:0]   rad_in,
    input  logic [COORD_WIDTH+1:0]     rem_in,
    input  logic [COORD_WIDTH-1:0]     root_in,
    output logic                       valid_out,
    output cordic_t                    cor_out,
    output logic [2*COORD_WIDTH-1:0]   rad_out,
    output logic [COORD_WIDTH+1:0]     rem_out,
    output logic [COORD_WIDTH-1:0]     root_out
);

    localparam int CW    = COORD_WIDTH;
    localparam int RAD_W = 2 * CW;
    localparam int REM_W = CW + 2;

    logic                    valid_reg;
    cordic_t                 cor_reg,  cor_next;
    logic [RAD_W-1:0]        rad_reg,  rad_next;
    logic [REM_W-1:0]        rem_reg,  rem_next;
    logic [CW-1:0]           root_reg, root_next;

    // rotation
    generate
        if (STEP < CORDIC_STEPS) begin : g_rot
            logic signed [XY_W-1:0]  cx, cy, cx_sh, cy_sh;
            logic signed [ANG_W-1:0] z, dz;
            assign cx    = cor_in.cx;
            assign cy    = cor_in.cy;
            assign z     = cor_in.z;
            assign cx_sh = cx >>> STEP;
            assign cy_sh = cy >>> STEP;
            assign dz    = atan_deg(5'(STEP));
            always_comb begin
                cor_next = cor_in;
                if (cy >= 0) begin
                    cor_next.cx = cx + cy_sh;
                    cor_next.cy = cy - cx_sh;
                    cor_next.z  = z + dz;
                end else begin
                    cor_next.cx = cx - cy_sh;
                    cor_next.cy = cy + cx_sh;
                    cor_next.z  = z - dz;
                end
            end
        end else begin : g_rot_pass
            assign cor_next = cor_in;
        end
    endgenerate

    // square root: one result bit, from the top, in each of the first CW stages
    generate
        if (STEP < CW) begin : g_sqrt
            logic [REM_W-1:0] rem_try, trial;
            logic             fits;
            assign rem_try = {rem_in[CW-1:0], rad_in[RAD_W-1 -: 2]};
            assign trial   = {root_in, 2'b01};
            assign fits    = (rem_try >= trial);
            assign rem_next  = fits ? (rem_try - trial) : rem_try;
            assign root_next = {root_in[CW-2:0], fits};
            assign rad_next  = {rad_in[RAD_W-3:0], 2'b00};
        end else begin : g_sqrt_pass
            assign rem_next  = rem_in;
            assign root_next = root_in;
            assign rad_next  = rad_in;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cor_reg  <= cor_next;
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_out = valid_reg;
    assign cor_out   = cor_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule

### rtl/rect_to_polar_converter_core.sv
// rectangular-to-polar converter: pipelined cordic angle and integer square root magnitude
//
// each input word carries a signed point (x_coord, y_coord); each result word carries
// round(sqrt(x^2+y^2)) as an unsigned integer and atan2(y, x) in 1/128 degree, from
// -180 to +180, with the negative x axis reading +180 and the origin reading 0. the
// datapath is a fixed pipeline: an input stage that folds the left half-plane by
// +-90 degrees and takes absolute values, a squaring stage, a sum stage, then
// N = max(COORD_WIDTH, CORDIC_STEPS) step stages, each doing one cordic
// micro-rotation and/or producing one bit of the square root, and finally a rounding
// step that writes into a two-word output buffer. one word is taken every cycle while
// the buffer is not full; a result is offered once its word has passed the input,
// squaring, sum, step and buffer registers. the whole pipeline advances together and
// holds only when the output buffer holds two unread results, so the input keeps
// being taken while one result waits, and no word is lost or repeated across stalls
module rect_to_polar_converter_core
    import r2p_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int GUARD = XY_SCALE_EXP - CW;
    localparam int NSTEP = (CW > CORDIC_STEPS) ? CW : CORDIC_STEPS;
    localparam int RAD_W = 2 * CW;
    localparam int REM_W = CW + 2;
    localparam int MAG_W = CW + 1;
    localparam int SAT_W = (MAG_W > 17) ? MAG_W : 17;

    // pipeline advance, held only when the output buffer is full
    logic en;

    // ------------------------------------------------------------------
    // input stage: reinterpret the coordinates, fold the left half-plane
    // ------------------------------------------------------------------
    logic signed [CW-1:0]   x_s, y_s;
    logic signed [CW:0]     x_e, y_e, cx_pre, cy_pre;
    logic signed [ANG_W-1:0] z_pre;
    logic [CW-1:0]          ax, ay;
    cordic_t                cor_pre;

    // bits above COORD_WIDTH are ignored, bits below are two's complement
    assign x_s = $signed(CW'($unsigned(s_data.x_coord)));
    assign y_s = $signed(CW'($unsigned(s_data.y_coord)));
    assign x_e = (CW+1)'(x_s);
    assign y_e = (CW+1)'(y_s);

    assign ax = (x_e < 0) ? CW'(-x_e) : CW'(x_e);
    assign ay = (y_e < 0) ? CW'(-y_e) : CW'(y_e);

    always_comb begin
        // left half-plane: rotate by -90 (upper) or +90 (lower) first
        if (x_e < 0) begin
            if (y_e >= 0) begin
                cx_pre = y_e;
                cy_pre = -x_e;
                z_pre  = DEG90;
            end else begin
                cx_pre = -y_e;
                cy_pre = x_e;
                z_pre  = -DEG90;
            end
        end else begin
            cx_pre = x_e;
            cy_pre = y_e;
            z_pre  = '0;
        end
        cor_pre.cx      = XY_W'(cx_pre) <<< GUARD;
        cor_pre.cy      = XY_W'(cy_pre) <<< GUARD;
        cor_pre.z       = z_pre;
        cor_pre.on_axis = (y_s == 0);
        cor_pre.neg_x   = (x_s < 0);
    end

    logic          p0_valid_reg;
    logic [CW-1:0] p0_ax_reg, p0_ay_reg;
    cordic_t       p0_cor_reg;

    // squaring stage
    logic             p1_valid_reg;
    logic [RAD_W-1:0] p1_sqx_reg, p1_sqy_reg, p1_sqx_next, p1_sqy_next;
    cordic_t          p1_cor_reg;

    // sum stage
    logic             p2_valid_reg;
    logic [RAD_W-1:0] p2_rad_reg, p2_rad_next;
    cordic_t          p2_cor_reg;

    assign p1_sqx_next = p0_ax_reg * p0_ax_reg;
    assign p1_sqy_next = p0_ay_reg * p0_ay_reg;
    // sum never exceeds 2^(2*CW-1), so no carry out
    assign p2_rad_next = p1_sqx_reg + p1_sqy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p0_valid_reg <= s_valid;
            p1_valid_reg <= p0_valid_reg;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_ax_reg  <= ax;
            p0_ay_reg  <= ay;
            p0_cor_reg <= cor_pre;
            p1_sqx_reg <= p1_sqx_next;
            p1_sqy_reg <= p1_sqy_next;
            p1_cor_reg <= p0_cor_reg;
            p2_rad_reg <= p2_rad_next;
            p2_cor_reg <= p1_cor_reg;
        end
    end

    // ------------------------------------------------------------------
    // step stages: rotation and root bit side by side
    // ------------------------------------------------------------------
    logic             st_valid [NSTEP+1];
    cordic_t          st_cor   [NSTEP+1];
    logic [RAD_W-1:0] st_rad   [NSTEP+1];
    logic [REM_W-1:0] st_rem   [NSTEP+1];
    logic [CW-1:0]    st_root  [NSTEP+1];

    assign st_valid[0] = p2_valid_reg;
    assign st_cor[0]   = p2_cor_reg;
    assign st_rad[0]   = p2_rad_reg;
    assign st_rem[0]   = '0;
    assign st_root[0]  = '0;

    generate
        for (genvar i = 0; i < NSTEP; i++) begin : g_step
            r2p_step #(
                .COORD_WIDTH  (COORD_WIDTH),
                .CORDIC_STEPS (CORDIC_STEPS),
                .STEP         (i)
            ) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .valid_in  (st_valid[i]),
                .cor_in    (st_cor[i]),
                .rad_in    (st_rad[i]),
                .rem_in    (st_rem[i]),
                .root_in   (st_root[i]),
                .valid_out (st_valid[i+1]),
                .cor_out   (st_cor[i+1]),
                .rad_out   (st_rad[i+1]),
                .rem_out   (st_rem[i+1]),
                .root_out  (st_root[i+1])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // rounding
    // ------------------------------------------------------------------
    logic                    round_up;
    logic [MAG_W-1:0]        mag_full;
    logic signed [ANG_W-1:0] z_last, z_round;
    out_word_t               res;

    // remainder is s - r*r; above r means nearer to r+1
    assign round_up = (st_rem[NSTEP] > REM_W'(st_root[NSTEP]));
    assign mag_full = MAG_W'(st_root[NSTEP]) + MAG_W'(round_up);
    assign z_last   = st_cor[NSTEP].z;
    assign z_round  = z_last + ANG_HALF;

    always_comb begin
        if (SAT_W'(mag_full) > SAT_W'(17'h0FFFF)) begin
            res.magnitude = 16'hFFFF;
        end else begin
            res.magnitude = 16'(mag_full);
        end
        // points on the x axis take their angle directly
        if (st_cor[NSTEP].on_axis) begin
            res.angle_deg = st_cor[NSTEP].neg_x ? DEG180_OUT : '0;
        end else begin
            res.angle_deg = z_round[ANG_DROP +: OUT_W];
        end
    end

    // ------------------------------------------------------------------
    // two-word output buffer
    // ------------------------------------------------------------------
    logic [1:0] cnt_reg, cnt_next;
    out_word_t  head_reg, head_next;
    out_word_t  tail_reg, tail_next;
    logic       push, pop;

    assign en      = (cnt_reg != 2'd2);
    assign s_ready = en;
    assign push    = en && st_valid[NSTEP];
    assign pop     = m_valid && m_ready;

    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && !pop) begin
            if (cnt_reg == 2'd0) begin
                head_next = res;
            end else begin
                tail_next = res;
            end
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end else if (push && pop) begin
            // only possible with one word held: replace it
            head_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = head_reg;

endmodule

### tb/r2p_tb_pkg.sv
// polar result predictor and scoreboard for the rectangular-to-polar testbench
`timescale 1ns / 1ps

package r2p_tb_pkg;

    import r2p_pkg::*;

    localparam int TB_GUARD = XY_SCALE_EXP - COORD_WIDTH_DEF;

    class polar_checker;

        out_word_t expected_polar[$];
        int        err_count;
        int        points_noted;
        int        results_checked;

        function new();
            err_count       = 0;
            points_noted    = 0;
            results_checked = 0;
        endfunction

        // atan(2^-k) in degrees, 20 fraction bits
        static function longint atan_step(int k);
            case (k)
                0:  return 47185920;
                1:  return 27855475;
                2:  return 14718068;
                3:  return 7471121;
                4:  return 3750058;
                5:  return 1876857;
                6:  return 938658;
                7:  return 469357;
                8:  return 234682;
                9:  return 117342;
                10: return 58671;
                11: return 29335;
                12: return 14668;
                13: return 7334;
                14: return 3667;
                15: return 1833;
                16: return 917;
                17: return 458;
                18: return 229;
                19: return 115;
                20: return 57;
                21: return 29;
                22: return 14;
                23: return 7;
                24: return 4;
                25: return 2;
                26: return 1;
                default: return 0;
            endcase
        endfunction

        function out_word_t predict_polar(in_word_t w);
            longint          x, y, cx, cy, nx, ny, z;
            longint unsigned ax, ay, sum_sq, rem, root, bitv;
            out_word_t       res;
            x = $signed(w.x_coord);
            y = $signed(w.y_coord);
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            sum_sq = ax * ax + ay * ay;

            // bitwise integer square root, rounded to nearest, capped at 65535
            rem  = sum_sq;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            if (sum_sq - root * root > root)
                root = root + 1;
            if (root > 64'd65535)
                root = 64'd65535;

            z = 0;
            if (y == 0) begin
                z = (x < 0) ? (longint'(180) <<< ANG_FRAC) : 0;
            end else begin
                // fold the left half-plane by +-90 degrees
                if (x < 0) begin
                    if (y >= 0) begin
                        cx = y;  cy = -x; z = longint'(90) <<< ANG_FRAC;
                    end else begin
                        cx = -y; cy = x;  z = -(longint'(90) <<< ANG_FRAC);
                    end
                end else begin
                    cx = x; cy = y;
                end
                cx = cx <<< TB_GUARD;
                cy = cy <<< TB_GUARD;
                for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                    if (cy >= 0) begin
                        nx = cx + (cy >>> (i % 32));
                        ny = cy - (cx >>> (i % 32));
                        z  = z + atan_step(i % 32);
                    end else begin
                        nx = cx - (cy >>> (i % 32));
                        ny = cy + (cx >>> (i % 32));
                        z  = z - atan_step(i % 32);
                    end
                    cx = nx;
                    cy = ny;
                end
            end
            z = (z + (longint'(1) <<< (ANG_DROP - 1))) >>> ANG_DROP;

            res.magnitude = root[15:0];
            res.angle_deg = z[15:0];
            return res;
        endfunction

        function void note_point(in_word_t w);
            expected_polar.push_back(predict_polar(w));
            points_noted++;
        endfunction

        function int pending();
            return expected_polar.size();
        endfunction

        task report_mismatch(string msg);
            if (err_count < 20)
                $display("mismatch: %s", msg);
            err_count++;
        endtask

        task check_polar(out_word_t got);
            out_word_t want;
            if (expected_polar.size() == 0) begin
                report_mismatch($sformatf("unexpected result mag=%0d ang=%0d",
                                          got.magnitude, $signed(got.angle_deg)));
            end else begin
                want = expected_polar.pop_front();
                results_checked++;
                if (got.magnitude !== want.magnitude)
                    report_mismatch($sformatf("result %0d magnitude got %0d want %0d",
                                              results_checked, got.magnitude,
                                              want.magnitude));
                if (got.angle_deg !== want.angle_deg)
                    report_mismatch($sformatf("result %0d angle got %0d want %0d",
                                              results_checked, $signed(got.angle_deg),
                                              $signed(want.angle_deg)));
            end
        endtask

        task check_drained();
            if (expected_polar.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          expected_polar.size()));
        endtask

    endclass

endpackage

### tb/rect_to_polar_converter_core_tb.sv
// top-level testbench for the rectangular-to-polar converter core
`timescale 1ns / 1ps

module rect_to_polar_converter_core_tb;

    import r2p_pkg::*;
    import r2p_tb_pkg::*;

    localparam int PHASE_WORDS = 475;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    // pipeline depth is max(width, steps) + 3, so this comfortably covers it
    localparam int TAIL_CYCLES = 60;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    polar_checker board;

    // idling knobs, percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    // long receiver hold-off: bumping hold_req starts one
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;

    rect_to_polar_converter_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // safety net in case the handshakes lock up
    initial begin
        #(2_000_000);
        $display("rect_to_polar_converter_core_tb NOT OK");
        $finish;
    end

    // receiver: random stalls, plus the long hold-off counted here
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // result monitor: every word taken is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_polar(m_data);
    end

    function automatic in_word_t mk_point(int x, int y);
        in_word_t w;
        w.x_coord = x[15:0];
        w.y_coord = y[15:0];
        return w;
    endfunction

    // random point, biased towards axes, extremes and the folding boundaries
    function automatic in_word_t random_point();
        int extremes[6];
        int x, y, kind;
        extremes = '{-32768, -32767, -1, 0, 1, 32767};
        kind = $urandom_range(9);
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
        case (kind)
            4: begin
                x = $urandom_range(127) - 64;
                y = $urandom_range(127) - 64;
            end
            5: begin
                if ($urandom_range(1)) y = 0;
                else x = 0;
            end
            6: begin
                x = extremes[$urandom_range(5)];
                y = extremes[$urandom_range(5)];
            end
            7: begin
                // diagonals in all four quadrants
                y = $urandom_range(1) ? x : -x;
                if (y > 32767) y = 32767;
            end
            8: begin
                // hugging the negative x axis from either side
                x = -($urandom_range(32768, 1));
                y = $urandom_range(2) - 1;
            end
            9: begin
                if ($urandom_range(1)) x = $urandom_range(15) - 8;
                else y = $urandom_range(15) - 8;
            end
            default: ;
        endcase
        return mk_point(x, y);
    endfunction

    // offer one word; entered and left just after a falling edge
    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_point(w);
        @(negedge aclk);
    endtask

    // stop offering until every outstanding result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        in_word_t directed[$];
        int       cnt;

        board = new();

        // origin, both axes and their signs, full-scale corners,
        // the folding boundaries around the negative x axis, and general points such as (3, 4)
        directed = '{
            mk_point(0, 0),          mk_point(32767, 0),      mk_point(-32768, 0),
            mk_point(-1, 0),         mk_point(1, 0),          mk_point(0, 32767),
            mk_point(0, -32768),     mk_point(0, 1),          mk_point(0, -1),
            mk_point(32767, 32767),  mk_point(-32768, -32768), mk_point(-32768, 32767),
            mk_point(32767, -32768), mk_point(-32768, 1),     mk_point(-32768, -1),
            mk_point(-1, 1),         mk_point(-1, -1),        mk_point(1, -1),
            mk_point(3, 4),          mk_point(-3, -4),        mk_point(12345, -23456),
            mk_point(-30000, 20000)
        };

        // reset held from the start, released on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i])
            send_word(directed[i]);

        // random phases: free running, sender gaps, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
                default: begin src_idle_pct = 23; snk_stall_pct = 23; end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // long hold-off with the sender flat out: the pipe fills and backs up
                if (phase == 0 && n == 200)
                    hold_req++;
                // sender goes quiet until the pipe has fully emptied
                if (phase == 1 && n == 200)
                    wait_drained();
                send_word(random_point());
            end
        end
        s_valid <= 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;

        cnt = 0;
        while (board.pending() != 0 && cnt < DRAIN_LIMIT) begin
            @(posedge aclk);
            cnt++;
        end
        if (board.pending() != 0)
            board.report_mismatch("timed out waiting for results");
        repeat (TAIL_CYCLES) @(posedge aclk);
        board.check_drained();

        $display("covered %0d points (axes, corners, half-plane folds, random) over four",
                 board.points_noted);
        $display("idling phases and one long output hold-off; %0d results checked, %0d errors",
                 board.results_checked, board.err_count);
        if (board.err_count == 0)
            $display("rect_to_polar_converter_core_tb OK");
        else
            $display("rect_to_polar_converter_core_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/r2p_pkg.sv
rtl/r2p_step.sv
rtl/rect_to_polar_converter_core.sv
tb/r2p_tb_pkg.sv
tb/rect_to_polar_converter_core_tb.sv
